// ===== rtl/mlbp_pkg.sv =====
`default_nettype none
package mlbp_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int COL_OUT_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_WID_W  = 12;
	localparam int LINE_W     = 2 * PIX_W + 1;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int MIN_DIM    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                 emit;
		logic                 frame_end;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
	} pos_t;

endpackage
`default_nettype wire

// ===== rtl/mlbp_ifs.sv =====
`default_nettype none
interface mlbp_pix_if import mlbp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] gray_pixel;
	logic             mask_bit;
	modport source(output valid, gray_pixel, mask_bit, input ready);
	modport sink(input valid, gray_pixel, mask_bit, output ready);
endinterface

interface mlbp_code_if import mlbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     lbp_code;
	logic [ROW_W-1:0]     center_row;
	logic [COL_OUT_W-1:0] center_col;
	logic                 frame_end;
	modport source(output valid, lbp_code, center_row, center_col, frame_end, input ready);
	modport sink(input valid, lbp_code, center_row, center_col, frame_end, output ready);
endinterface

interface mlbp_cfg_if import mlbp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mlbp_line_mem.sv =====
`default_nettype none
module mlbp_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 17
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          re,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// ===== rtl/mlbp_scan.sv =====
`default_nettype none
module mlbp_scan import mlbp_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int AW        = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  acc,
	output logic      [AW-1:0]         addr,
	output pos_t                       pos
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

	logic [WW-1:0]        width_q;
	logic [ROW_W-1:0]     height_q;
	logic [AW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;
	logic [CFG_WID_W-1:0] wr_w;
	logic [WW-1:0]        new_w;
	logic [ROW_W-1:0]     new_h;
	logic                 col_last;
	logic                 row_last;
	logic [AW-1:0]        col_m1;

	always_comb begin
		wr_w = cfg_data[CFG_WID_W-1:0];
		if (int'(wr_w) < MIN_DIM) begin
			new_w = WW'(MIN_DIM);
		end else if (int'(wr_w) > MAX_WIDTH) begin
			new_w = WW'(MAX_WIDTH);
		end else begin
			new_w = WW'(wr_w);
		end
		if (int'(cfg_data) < MIN_DIM) begin
			new_h = ROW_W'(MIN_DIM);
		end else begin
			new_h = cfg_data;
		end
	end

	assign col_last = (WW'(col_q) == width_q - WW'(1));
	assign row_last = (row_q == height_q - ROW_W'(1));
	assign col_m1   = col_q - AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= ROW_W'(RST_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT)) begin
			if (cfg_idx == REG_IMAGE_WIDTH) begin
				width_q <= new_w;
			end else begin
				height_q <= new_h;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign addr          = col_q;
	assign pos.emit      = (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
	assign pos.frame_end = row_last && col_last;
	assign pos.row       = row_q - ROW_W'(1);
	assign pos.col       = COL_OUT_W'(col_m1);

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < width_q) else $error("column count beyond row width");
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < height_q) else $error("row count beyond frame height");

endmodule
`default_nettype wire

// ===== rtl/mlbp_window.sv =====
`default_nettype none
module mlbp_window import mlbp_pkg::*; #(
	parameter int AW = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      in_pix,
	input  wire logic                  in_mask,
	input  wire pos_t                  in_pos,
	input  wire logic [AW-1:0]         in_addr,
	input  wire logic [LINE_W-1:0]     rd_data,
	output logic                       wr_en,
	output logic      [AW-1:0]         wr_addr,
	output logic      [LINE_W-1:0]     wr_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [PIX_W-1:0]      out_code,
	output logic      [ROW_W-1:0]      out_row,
	output logic      [COL_OUT_W-1:0]  out_col,
	output logic                       out_fend
);

	logic                 valid_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic                 msk_s1;
	pos_t                 pos_s1;
	logic [AW-1:0]        addr_s1;
	logic [PIX_W-1:0]     win_q [6];
	logic                 cmask_q;
	logic                 oval_q;
	logic [PIX_W-1:0]     code_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_OUT_W-1:0] col_q;
	logic                 fend_q;
	logic                 acc;
	logic                 out_busy;
	logic                 s1_adv;
	logic [PIX_W-1:0]     top;
	logic [PIX_W-1:0]     mid;
	logic                 up_mask;
	logic [PIX_W-1:0]     ctr;
	logic [PIX_W-1:0]     code_c;

	assign top     = rd_data[2*PIX_W-1:PIX_W];
	assign mid     = rd_data[PIX_W-1:0];
	assign up_mask = rd_data[LINE_W-1];

	assign out_busy = oval_q && !out_ready;
	assign s1_adv   = valid_s1 && !(pos_s1.emit && out_busy);
	assign in_ready = !valid_s1 || s1_adv;
	assign acc      = in_valid && in_ready;

	assign wr_en   = s1_adv;
	assign wr_addr = addr_s1;
	assign wr_data = {msk_s1, mid, pix_s1};

	always_comb begin
		ctr    = win_q[3];
		code_c = '0;
		if (cmask_q) begin
			code_c = {win_q[0] > ctr, win_q[1] > ctr, top > ctr, mid > ctr,
				pix_s1 > ctr, win_q[5] > ctr, win_q[4] > ctr, win_q[2] > ctr};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_adv && pos_s1.emit) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= in_pix;
			msk_s1  <= in_mask;
			pos_s1  <= in_pos;
			addr_s1 <= in_addr;
		end
		if (s1_adv) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
			cmask_q  <= up_mask;
		end
		if (s1_adv && pos_s1.emit) begin
			code_q <= code_c;
			row_q  <= pos_s1.row;
			col_q  <= pos_s1.col;
			fend_q <= pos_s1.frame_end;
		end
	end

	assign out_valid = oval_q;
	assign out_code  = code_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_fend  = fend_q;

	a_acc_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1) else $error("accepted pixel lost before the window stage");
	a_code_drains: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && out_ready && !(s1_adv && pos_s1.emit) |=> !oval_q)
		else $error("taken code still shown as valid");
	a_center_interior: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q |-> row_q != '0 && col_q != '0) else $error("code for a border pixel");

endmodule
`default_nettype wire

// ===== rtl/masked_lbp_3x3.sv =====
// Output: the pixel that completes a window is registered in the window stage, and its code is
// then registered in the output register, where it is held until it is taken.
// Throughput: one pixel per cycle; input stalls only when the output register holds
// an untaken code and the window stage holds the next one.
// Reset: width 640, height 480, scan position at row 0 column 0, pipeline empty.
// The line memory is not cleared; rows 0 and 1 of each frame refill every entry a code uses.
`default_nettype none
module masked_lbp_3x3 import mlbp_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mlbp_pix_if.sink    pix,
	mlbp_code_if.source lbp,
	mlbp_cfg_if.sink    cfg
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic              acc;
	logic              in_ready;
	logic [AW-1:0]     rd_addr;
	pos_t              pos;
	logic [LINE_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [LINE_W-1:0] wr_data;

	assign cfg.ready = 1'b1;
	assign pix.ready = in_ready;
	assign acc       = pix.valid && in_ready;

	mlbp_scan #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg.valid),
		.cfg_idx(cfg.index),
		.cfg_data(cfg.data),
		.acc(acc),
		.addr(rd_addr),
		.pos(pos)
	);

	mlbp_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW(AW),
		.DW(LINE_W)
	) u_mem (
		.clk(clk),
		.we(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.re(acc),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	mlbp_window #(
		.AW(AW)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pix.valid),
		.in_ready(in_ready),
		.in_pix(pix.gray_pixel),
		.in_mask(pix.mask_bit),
		.in_pos(pos),
		.in_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.out_valid(lbp.valid),
		.out_ready(lbp.ready),
		.out_code(lbp.lbp_code),
		.out_row(lbp.center_row),
		.out_col(lbp.center_col),
		.out_fend(lbp.frame_end)
	);

endmodule
`default_nettype wire
